### rtl/pef_pkg.sv
// Package for the priority evicting descriptor queue.
// Holds request/response structs, entry type, codes and sizing constants.
// No dependencies.
package pef_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [12:0] PAYLOAD_LIMIT_RESET = 13'd2048;
   localparam logic [4:0]  CAPACITY_RESET      = 5'd16;

   // request codes
   localparam logic [1:0] REQ_ENQ   = 2'd0;
   localparam logic [1:0] REQ_DEQ   = 2'd1;
   localparam logic [1:0] REQ_PEEK  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   // priorities
   localparam logic [1:0] PRI_NORMAL   = 2'd0;
   localparam logic [1:0] PRI_HAZARD   = 2'd1;
   localparam logic [1:0] PRI_CRITICAL = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_NOROOM = 2'd2;
   localparam logic [1:0] ST_TOOBIG = 2'd3;

   // register indexes
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_LIMIT    = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [1:0]  priority_req;
      logic [31:0] sequence_req;
      logic [15:0] payload_ref;
      logic [11:0] payload_bytes;
      logic [31:0] time_msec;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        evicted;
      logic [31:0] out_sequence;
      logic [1:0]  out_priority;
      logic [15:0] out_payload_ref;
      logic [11:0] out_payload_len;
      logic [31:0] out_timestamp;
      logic [4:0]  occupancy;
      logic [31:0] enqueue_total;
      logic [31:0] dequeue_total;
      logic [31:0] normal_drops;
      logic [31:0] hazard_drops;
   } rsp_type_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [1:0]  pri;
      logic [15:0] ref_h;
      logic [11:0] len;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic valid;  // position holds a live entry
      logic shift;  // take the neighbor's entry
      logic load;   // take the incoming entry
   } cell_ctl_type;

endpackage

### rtl/pef_cell.sv
// One queue position: holds an entry, shifts toward the head on removal.
// Passes a running "normal entry seen" flag to the next position.
// Depends on pef_pkg.
module pef_cell import pef_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    new_entry,
   input  entry_type    next_entry,
   input  logic         seen_in,
   output logic         seen_out,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      priority if (ctl.load) begin
         entry_in = new_entry;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign seen_out = seen_in | (ctl.valid & (entry_ff.pri == PRI_NORMAL));
   assign entry    = entry_ff;

endmodule

### rtl/priority_evicting_fifo_top.sv
// Top level of the priority evicting descriptor queue.
// Instantiates a row of pef_cell positions; depends on pef_pkg.
//
// Usage:
//   req_* carries one request (enqueue, dequeue, peek, clear) as a packed
//   struct; a transfer happens when req_valid is high and req_stall is low.
//   rsp_* returns exactly one result per request, in order, with the same
//   valid/stall rules. csr_* writes capacity_in_use (index 0) and
//   payload_limit (index 1) whenever csr_we is high; write only while idle.
//   Latency: the result is shown the cycle after the request transfer.
//   Throughput: one request per cycle unless stalled. The oldest-normal
//   search is a flag rippling down the row of cells, and removal shifts
//   the cells behind the removed position toward the head in the same cycle.
//   Receiver stall: the registered result holds; req_stall rises while a
//   result waits and rsp_stall is high, and falls as soon as it is taken.
//   Reset (synchronous, active high): queue empty, counters zero,
//   capacity 16, payload limit 2048; no clearing pass is needed.
module priority_evicting_fifo_top import pef_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [12:0]  csr_wdata
);

   logic [4:0]       capacity_ff;
   logic [12:0]      limit_ff;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [31:0]      enq_ff, enq_in;
   logic [31:0]      deq_ff, deq_in;
   logic [31:0]      ndrop_ff, ndrop_in;
   logic [31:0]      hdrop_ff, hdrop_in;
   logic             rsp_valid_ff;
   rsp_type_type     rsp_ff, rsp_in;

   cell_ctl_type     ctl [DEPTH];
   entry_type        cell_entry [DEPTH];
   logic [DEPTH:0]   seen;
   logic [DEPTH-1:0] valid_vec;

   logic             go;
   logic [1:0]       pri_fix;
   logic [CNT_W-1:0] eff_cap;
   logic             too_big, full, found;
   logic             enq_ok, evict_go, deq_go, write_go;
   logic [CNT_W-1:0] wr_pos;
   entry_type        new_entry;

   assign go        = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;

   assign pri_fix = (req_data.priority_req == 2'd3) ? PRI_CRITICAL : req_data.priority_req;

   always_comb begin
      priority if (capacity_ff == 5'd0) begin
         eff_cap = CNT_W'(1);
      end else if (CNT_W'(capacity_ff) > CNT_W'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
   end

   assign too_big = {1'b0, req_data.payload_bytes} >= limit_ff;
   assign full    = held_ff >= eff_cap;
   assign found   = seen[DEPTH];

   assign enq_ok   = go & (req_data.req_type == REQ_ENQ) & ~too_big;
   assign evict_go = enq_ok & full & found;
   assign write_go = enq_ok & (~full | found);
   assign deq_go   = go & (req_data.req_type == REQ_DEQ) & (held_ff != '0);
   // eviction frees the tail slot, so the new entry lands one place lower
   assign wr_pos   = evict_go ? held_ff - CNT_W'(1) : held_ff;

   assign new_entry.seq   = req_data.sequence_req;
   assign new_entry.pri   = pri_fix;
   assign new_entry.ref_h = req_data.payload_ref;
   assign new_entry.len   = req_data.payload_bytes;
   assign new_entry.stamp = req_data.time_msec;

   assign seen[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic      nxt_valid;
         entry_type nxt_entry;

         assign valid_vec[gi] = held_ff > CNT_W'(gi);

         if (gi == DEPTH - 1) begin : g_last
            assign nxt_valid = 1'b0;
            assign nxt_entry = '0;
         end else begin : g_mid
            assign nxt_valid = held_ff > CNT_W'(gi + 1);
            assign nxt_entry = cell_entry[gi + 1];
         end

         always_comb begin
            ctl[gi].valid = valid_vec[gi];
            ctl[gi].shift = nxt_valid & (deq_go | (evict_go & seen[gi + 1]));
            ctl[gi].load  = write_go & (wr_pos == CNT_W'(gi));
         end

         pef_cell u_cell (
            .clock      (clock),
            .ctl        (ctl[gi]),
            .new_entry  (new_entry),
            .next_entry (nxt_entry),
            .seen_in    (seen[gi]),
            .seen_out   (seen[gi + 1]),
            .entry      (cell_entry[gi])
         );
      end
   endgenerate

   // next state and result
   always_comb begin
      held_in  = held_ff;
      enq_in   = enq_ff;
      deq_in   = deq_ff;
      ndrop_in = ndrop_ff;
      hdrop_in = hdrop_ff;
      rsp_in   = '0;

      unique case (req_data.req_type)
         REQ_ENQ: begin
            if (too_big) begin
               rsp_in.status = ST_TOOBIG;
            end else if (full & ~found) begin
               rsp_in.status = ST_NOROOM;
               if (pri_fix == PRI_HAZARD) begin
                  hdrop_in = hdrop_ff + 32'd1;
               end else if (pri_fix == PRI_NORMAL) begin
                  ndrop_in = ndrop_ff + 32'd1;
               end
            end else begin
               enq_in = enq_ff + 32'd1;
               if (full) begin
                  rsp_in.evicted = 1'b1;
                  ndrop_in       = ndrop_ff + 32'd1;
               end else begin
                  held_in = held_ff + CNT_W'(1);
               end
            end
         end
         REQ_DEQ, REQ_PEEK: begin
            if (held_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.out_sequence    = cell_entry[0].seq;
               rsp_in.out_priority    = cell_entry[0].pri;
               rsp_in.out_payload_ref = cell_entry[0].ref_h;
               rsp_in.out_payload_len = cell_entry[0].len;
               rsp_in.out_timestamp   = cell_entry[0].stamp;
               if (req_data.req_type == REQ_DEQ) begin
                  held_in = held_ff - CNT_W'(1);
                  deq_in  = deq_ff + 32'd1;
               end
            end
         end
         REQ_CLEAR: begin
            held_in = '0;
         end
         default: begin
            held_in = held_ff;
         end
      endcase

      rsp_in.occupancy     = 5'(held_in);
      rsp_in.enqueue_total = enq_in;
      rsp_in.dequeue_total = deq_in;
      rsp_in.normal_drops  = ndrop_in;
      rsp_in.hazard_drops  = hdrop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         limit_ff     <= PAYLOAD_LIMIT_RESET;
         held_ff      <= '0;
         enq_ff       <= '0;
         deq_ff       <= '0;
         ndrop_ff     <= '0;
         hdrop_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CAPACITY: capacity_ff <= csr_wdata[4:0];
               CSR_LIMIT:    limit_ff    <= csr_wdata;
               default:      limit_ff    <= limit_ff;
            endcase
         end
         if (go) begin
            held_ff  <= held_in;
            enq_ff   <= enq_in;
            deq_ff   <= deq_in;
            ndrop_ff <= ndrop_in;
            hdrop_ff <= hdrop_in;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### tb/priority_evicting_fifo_top_tb.sv
// Testbench for priority_evicting_fifo_top: directed and random request traffic,
// each result checked against a cycle-free model of the descriptor queue.
// Depends on pef_pkg and the priority_evicting_fifo_top RTL.
`timescale 1ns / 1ps

module priority_evicting_fifo_top_tb import pef_pkg::*; ();

   // unassigned priority code, stored as critical
   localparam logic [1:0] PRI_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTS  = 30;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_type_type rsp_data;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_CAPACITY;
   logic [12:0]  csr_wdata = '0;

   priority_evicting_fifo_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // queue model state
   entry_type   queue_entries [DEPTH];
   int unsigned queue_fill = 0;
   logic [31:0] enq_total = '0;
   logic [31:0] deq_total = '0;
   logic [31:0] normal_drop_total = '0;
   logic [31:0] hazard_drop_total = '0;
   logic [4:0]  capacity_reg = CAPACITY_RESET;
   logic [12:0] limit_reg = PAYLOAD_LIMIT_RESET;

   rsp_type_type expected_rsp [$];
   int mismatches = 0;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   function automatic void remove_entry(input int unsigned pos);
      for (int unsigned i = pos; i + 1 < queue_fill; i++)
         queue_entries[i] = queue_entries[i + 1];
      if (queue_fill > 0) queue_fill--;
   endfunction

   function automatic rsp_type_type predict_response(input req_type_type r);
      rsp_type_type rsp;
      logic [1:0]   pri;
      int unsigned  cap;
      int           pos;
      bit           room;
      rsp = '0;
      pri = (r.priority_req == PRI_SPARE) ? PRI_CRITICAL : r.priority_req;
      cap = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      case (r.req_type)
         REQ_ENQ: begin
            if ({1'b0, r.payload_bytes} >= limit_reg) begin
               rsp.status = ST_TOOBIG;
            end else begin
               room = 1'b1;
               if (queue_fill >= cap) begin
                  pos = -1;
                  for (int i = 0; i < queue_fill; i++)
                     if (pos < 0 && queue_entries[i].pri == PRI_NORMAL) pos = i;
                  if (pos >= 0) begin
                     remove_entry(pos);
                     normal_drop_total++;
                     rsp.evicted = 1'b1;
                  end else begin
                     room = 1'b0;
                     rsp.status = ST_NOROOM;
                     if (pri == PRI_HAZARD) hazard_drop_total++;
                     else if (pri == PRI_NORMAL) normal_drop_total++;
                  end
               end
               if (room && queue_fill < DEPTH) begin
                  queue_entries[queue_fill].seq   = r.sequence_req;
                  queue_entries[queue_fill].pri   = pri;
                  queue_entries[queue_fill].ref_h = r.payload_ref;
                  queue_entries[queue_fill].len   = r.payload_bytes;
                  queue_entries[queue_fill].stamp = r.time_msec;
                  queue_fill++;
                  enq_total++;
               end
            end
         end
         REQ_DEQ, REQ_PEEK: begin
            if (queue_fill == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.out_sequence    = queue_entries[0].seq;
               rsp.out_priority    = queue_entries[0].pri;
               rsp.out_payload_ref = queue_entries[0].ref_h;
               rsp.out_payload_len = queue_entries[0].len;
               rsp.out_timestamp   = queue_entries[0].stamp;
               if (r.req_type == REQ_DEQ) begin
                  remove_entry(0);
                  deq_total++;
               end
            end
         end
         default: queue_fill = 0;
      endcase
      rsp.occupancy     = queue_fill[4:0];
      rsp.enqueue_total = enq_total;
      rsp.dequeue_total = deq_total;
      rsp.normal_drops  = normal_drop_total;
      rsp.hazard_drops  = hazard_drop_total;
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_PRINTS)
         $display("%0t: mismatch %s: got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic check_response(input rsp_type_type got, input rsp_type_type want);
      compare_field("status", got.status, want.status);
      compare_field("evicted", got.evicted, want.evicted);
      compare_field("out_sequence", got.out_sequence, want.out_sequence);
      compare_field("out_priority", got.out_priority, want.out_priority);
      compare_field("out_payload_ref", got.out_payload_ref, want.out_payload_ref);
      compare_field("out_payload_len", got.out_payload_len, want.out_payload_len);
      compare_field("out_timestamp", got.out_timestamp, want.out_timestamp);
      compare_field("occupancy", got.occupancy, want.occupancy);
      compare_field("enqueue_total", got.enqueue_total, want.enqueue_total);
      compare_field("dequeue_total", got.dequeue_total, want.dequeue_total);
      compare_field("normal_drops", got.normal_drops, want.normal_drops);
      compare_field("hazard_drops", got.hazard_drops, want.hazard_drops);
   endtask

   // result side: one transfer per edge with valid high and stall low
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) report_mismatch("result with none expected", 0, 0);
         else check_response(rsp_data, expected_rsp.pop_front());
      end
   end

   // receiver stall; a requested hold-off is counted down here
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left = HOLD_CYCLES;
         hold_served = hold_requests;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** priority_evicting_fifo_top: FAILED **");
         $finish;
      end
   end

   // valid is left high after a transfer; the next call either reloads data
   // in the same step or drops valid for a gap
   task automatic send_request(input req_type_type item);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(predict_response(item));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [12:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CAPACITY) capacity_reg = value[4:0];
      else limit_reg = value;
   endtask

   function automatic req_type_type make_request(input logic [1:0] kind,
         input logic [1:0] pri, input logic [31:0] seq, input logic [31:0] handle,
         input logic [11:0] len, input logic [31:0] stamp);
      req_type_type r;
      r.req_type      = kind;
      r.priority_req  = pri;
      r.sequence_req  = seq;
      r.payload_ref   = handle[15:0];
      r.payload_bytes = len;
      r.time_msec     = stamp;
      return r;
   endfunction

   function automatic req_type_type random_request();
      req_type_type r;
      int unsigned  pick;
      int unsigned  len_max;
      r.sequence_req = $urandom();
      r.payload_ref  = 16'($urandom());
      r.time_msec    = $urandom();
      pick = $urandom_range(99);
      r.priority_req = (pick < 35) ? PRI_NORMAL : (pick < 65) ? PRI_HAZARD :
                       (pick < 93) ? PRI_CRITICAL : PRI_SPARE;
      pick = $urandom_range(99);
      r.req_type = (pick < 55) ? REQ_ENQ : (pick < 83) ? REQ_DEQ :
                   (pick < 97) ? REQ_PEEK : REQ_CLEAR;
      // mostly lengths that fit; some of any size
      if (limit_reg == 0 || $urandom_range(99) < 8) begin
         r.payload_bytes = 12'($urandom());
      end else begin
         len_max = (limit_reg > 4096) ? 4095 : limit_reg - 1;
         r.payload_bytes = 12'($urandom_range(len_max, 0));
      end
      return r;
   endfunction

   task automatic test_basic_requests();
      send_request(make_request(REQ_PEEK, PRI_NORMAL, 0, 0, 0, 0));
      send_request(make_request(REQ_DEQ, PRI_NORMAL, 0, 0, 0, 0));
      send_request(make_request(REQ_ENQ, PRI_NORMAL, '0, '0, 12'd0, '0));
      send_request(make_request(REQ_ENQ, PRI_HAZARD, '1, '1, 12'd2047, '1));
      send_request(make_request(REQ_ENQ, PRI_CRITICAL, $urandom(), $urandom(), 12'd2048,
                                $urandom()));
      send_request(make_request(REQ_ENQ, PRI_NORMAL, $urandom(), $urandom(), 12'hFFF,
                                $urandom()));
      send_request(make_request(REQ_ENQ, PRI_SPARE, $urandom(), $urandom(), 12'd77,
                                $urandom()));
      send_request(make_request(REQ_PEEK, PRI_NORMAL, 0, 0, 0, 0));
      repeat (3) send_request(make_request(REQ_DEQ, PRI_SPARE, '1, '1, '1, '1));
      send_request(make_request(REQ_ENQ, PRI_HAZARD, $urandom(), $urandom(), 12'd5,
                                $urandom()));
      send_request(make_request(REQ_CLEAR, PRI_NORMAL, 0, 0, 0, 0));
      send_request(make_request(REQ_PEEK, PRI_NORMAL, 0, 0, 0, 0));
   endtask

   task automatic test_payload_limit();
      write_register(CSR_LIMIT, 13'd0);
      send_request(make_request(REQ_ENQ, PRI_CRITICAL, $urandom(), $urandom(), 12'd0,
                                $urandom()));
      write_register(CSR_LIMIT, 13'd1);
      send_request(make_request(REQ_ENQ, PRI_NORMAL, $urandom(), $urandom(), 12'd0,
                                $urandom()));
      send_request(make_request(REQ_ENQ, PRI_NORMAL, $urandom(), $urandom(), 12'd1,
                                $urandom()));
      write_register(CSR_LIMIT, 13'h1FFF);
      send_request(make_request(REQ_ENQ, PRI_HAZARD, $urandom(), $urandom(), 12'hFFF,
                                $urandom()));
      write_register(CSR_LIMIT, 13'd4096);
      send_request(make_request(REQ_ENQ, PRI_NORMAL, $urandom(), $urandom(), 12'hFFF,
                                $urandom()));
      send_request(make_request(REQ_CLEAR, PRI_NORMAL, 0, 0, 0, 0));
   endtask

   task automatic test_capacity_limits();
      // zero capacity acts as one: insert, evict, then refusals of every priority
      write_register(CSR_CAPACITY, 13'd0);
      send_request(make_request(REQ_ENQ, PRI_NORMAL, $urandom(), $urandom(), 12'd1,
                                $urandom()));
      send_request(make_request(REQ_ENQ, PRI_HAZARD, $urandom(), $urandom(), 12'd2,
                                $urandom()));
      send_request(make_request(REQ_ENQ, PRI_NORMAL, $urandom(), $urandom(), 12'd3,
                                $urandom()));
      send_request(make_request(REQ_ENQ, PRI_HAZARD, $urandom(), $urandom(), 12'd4,
                                $urandom()));
      send_request(make_request(REQ_ENQ, PRI_CRITICAL, $urandom(), $urandom(), 12'd5,
                                $urandom()));
      send_request(make_request(REQ_ENQ, PRI_SPARE, $urandom(), $urandom(), 12'd6,
                                $urandom()));
      // out of range capacity acts as the full depth
      write_register(CSR_CAPACITY, 13'h1F);
      repeat (3) send_request(make_request(REQ_ENQ, PRI_NORMAL, $urandom(), $urandom(),
                                           12'($urandom_range(100)), $urandom()));
      // capacity under occupancy: each insert evicts one normal entry
      write_register(CSR_CAPACITY, 13'd2);
      repeat (2) send_request(make_request(REQ_ENQ, PRI_CRITICAL, $urandom(), $urandom(),
                                           12'd9, $urandom()));
      send_request(make_request(REQ_CLEAR, PRI_NORMAL, 0, 0, 0, 0));
      write_register(CSR_CAPACITY, 13'd16);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stalls, input int count);
      logic [12:0] value;
      sender_idle_pct = idle_pct;
      stall_pct = stalls;
      repeat (2) begin
         case ($urandom_range(4))
            0: value = 13'd1;
            1: value = 13'd2;
            2: value = 13'd4;
            3: value = 13'd16;
            default: value = 13'($urandom_range(31));
         endcase
         write_register(CSR_CAPACITY, value);
         case ($urandom_range(3))
            0: value = 13'($urandom_range(4096, 1));
            1: value = 13'd4096;
            2: value = PAYLOAD_LIMIT_RESET;
            default: value = 13'($urandom_range(8191, 1));
         endcase
         write_register(CSR_LIMIT, value);
         repeat (count / 2) send_request(random_request());
      end
   endtask

   // receiver holds off while the sender keeps offering, so input stalls
   task automatic test_output_holdoff();
      req_type_type item;
      write_register(CSR_CAPACITY, 13'd8);
      sender_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (40) begin
         item = random_request();
         if ($urandom_range(99) < 80) item.req_type = REQ_ENQ;
         send_request(item);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_basic_requests();
      test_payload_limit();
      test_capacity_limits();
      test_random_traffic(0, 0, 500);
      test_random_traffic(51, 0, 500);
      test_random_traffic(0, 51, 500);
      test_random_traffic(6, 6, 500);
      test_output_holdoff();
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("** priority_evicting_fifo_top: PASSED **");
      end else begin
         $display("** priority_evicting_fifo_top: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
rtl/pef_pkg.sv
rtl/pef_cell.sv
rtl/priority_evicting_fifo_top.sv
tb/priority_evicting_fifo_top_tb.sv
